// File: rtl/core/rgb_to_hsv_convert_top_macros.svh
// Assertion macros for the RGB to HSV converter checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef RGB_TO_HSV_CONVERT_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERT_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RHC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhc: same-cycle check failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhc: next-cycle check failed");

`endif

// File: rtl/core/rhc_pkg.sv
// Shared constants and the per-cell data word of the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
package rhc_pkg;

	localparam int HUE_BITS = 16;              // hue resolution, 8..24
	localparam int CH_W     = 8;               // channel width
	localparam int HREM_W   = 11;              // holds 6*(max-min) <= 1530
	localparam int SAT_NW   = HUE_BITS + CH_W; // widened saturation dividend

	// Everything one division cell needs to hand to its neighbor.
	typedef struct packed {
		logic [HREM_W-1:0]   hue_rem;
		logic [HREM_W-1:0]   hue_div;
		logic [HUE_BITS-1:0] hue_q;
		logic [CH_W-1:0]     sat_rem;
		logic [CH_W-1:0]     sat_div;
		logic [HUE_BITS-1:0] sat_sh;
		logic [CH_W-1:0]     sat_q;
		logic [CH_W-1:0]     val;
	} cell_data_t;

endpackage

// File: rtl/core/rhc_stream_ifs.sv
// Valid/ready stream interfaces for RGB pixels in and HSV results out.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
interface rhc_rgb_if;
	logic                   valid;
	logic                   ready;
	logic [rhc_pkg::CH_W-1:0] red_in;
	logic [rhc_pkg::CH_W-1:0] green_in;
	logic [rhc_pkg::CH_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface rhc_hsv_if;
	logic                       valid;
	logic                       ready;
	logic [rhc_pkg::HUE_BITS-1:0] hue_out;
	logic [rhc_pkg::CH_W-1:0]     sat_out;
	logic [rhc_pkg::CH_W-1:0]     val_out;

	modport source (output valid, output hue_out, output sat_out, output val_out,
		input ready);
	modport sink (input valid, input hue_out, input sat_out, input val_out,
		output ready);
endinterface

// File: rtl/core/rhc_prep.sv
// Front stage: max/min, hue numerator and divisors, saturation dividend.
// Depends on rhc_pkg and rhc_rgb_if.
`timescale 1ns / 1ps
module rhc_prep (
	input  logic                clk,
	input  logic                arst_n,
	rhc_rgb_if.sink             pix,
	output logic                valid,
	output rhc_pkg::cell_data_t data,
	input  logic                ready
);
	logic [rhc_pkg::CH_W-1:0]   r, g, b, mx, mn, d;
	logic                       red_max, green_max;
	logic signed [11:0]         num;
	logic [rhc_pkg::HREM_W-1:0] d6;
	logic [15:0]                sat_num;
	logic [rhc_pkg::SAT_NW-1:0] sat_w;
	rhc_pkg::cell_data_t        nxt;
	logic                       valid_s1;
	rhc_pkg::cell_data_t        data_s1;

	assign r = pix.red_in;
	assign g = pix.green_in;
	assign b = pix.blue_in;

	// red wins ties, then green
	assign red_max   = (r >= g) && (r >= b);
	assign green_max = !red_max && (g >= b);

	always_comb begin
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end

	assign d       = mx - mn;
	assign d6      = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
	assign sat_num = {d, 8'h00} - {8'h00, d};
	assign sat_w   = rhc_pkg::SAT_NW'(sat_num);

	always_comb begin
		if (red_max) begin
			num = 12'(signed'({4'h0, g})) - 12'(signed'({4'h0, b}));
			if (num < 0) num = num + 12'(signed'({1'b0, d6}));
		end else if (green_max) begin
			num = 12'(signed'({4'h0, b})) - 12'(signed'({4'h0, r}))
				+ 12'(signed'({3'b000, d, 1'b0}));
		end else begin
			num = 12'(signed'({4'h0, r})) - 12'(signed'({4'h0, g}))
				+ 12'(signed'({2'b00, d, 2'b00}));
		end
	end

	always_comb begin
		nxt.hue_rem = (d == '0) ? '0 : num[rhc_pkg::HREM_W-1:0];
		nxt.hue_div = (d == '0) ? '1 : d6;          // zero quotient when gray
		nxt.hue_q   = '0;
		nxt.sat_rem = rhc_pkg::CH_W'(sat_w >> rhc_pkg::HUE_BITS);
		nxt.sat_div = (mx == '0) ? '1 : mx;         // black: dividend is zero
		nxt.sat_sh  = sat_w[rhc_pkg::HUE_BITS-1:0];
		nxt.sat_q   = '0;
		nxt.val     = mx;
	end

	assign pix.ready = !valid_s1 || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			data_s1 <= nxt;
		end
	end

	assign valid = valid_s1;
	assign data  = data_s1;
endmodule

// File: rtl/core/rhc_cell.sv
// One restoring-division cell: one hue quotient bit and one saturation bit.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rhc_pkg::cell_data_t in_data,
	output logic                in_ready,
	output logic                out_valid,
	output rhc_pkg::cell_data_t out_data,
	input  logic                out_ready
);
	logic [rhc_pkg::HREM_W:0] hrem_sh, hdiff;
	logic                     hge;
	logic [rhc_pkg::CH_W:0]   srem_sh, sdiff;
	logic                     sge;
	rhc_pkg::cell_data_t      nxt;
	logic                     valid_q;
	rhc_pkg::cell_data_t      data_q;

	// hue: fraction bits of num / div, remainder doubles each step
	assign hrem_sh = {in_data.hue_rem, 1'b0};
	assign hge     = hrem_sh >= {1'b0, in_data.hue_div};
	assign hdiff   = hrem_sh - {1'b0, in_data.hue_div};

	// saturation: long division, dividend bits shifted in MSB first
	assign srem_sh = {in_data.sat_rem, in_data.sat_sh[rhc_pkg::HUE_BITS-1]};
	assign sge     = srem_sh >= {1'b0, in_data.sat_div};
	assign sdiff   = srem_sh - {1'b0, in_data.sat_div};

	always_comb begin
		nxt         = in_data;
		nxt.hue_rem = hge ? hdiff[rhc_pkg::HREM_W-1:0] : hrem_sh[rhc_pkg::HREM_W-1:0];
		nxt.hue_q   = {in_data.hue_q[rhc_pkg::HUE_BITS-2:0], hge};
		nxt.sat_rem = sge ? sdiff[rhc_pkg::CH_W-1:0] : srem_sh[rhc_pkg::CH_W-1:0];
		nxt.sat_sh  = {in_data.sat_sh[rhc_pkg::HUE_BITS-2:0], 1'b0};
		nxt.sat_q   = {in_data.sat_q[rhc_pkg::CH_W-2:0], sge};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

// File: rtl/core/rgb_to_hsv_convert_top.sv
// RGB to HSV converter: one 8-bit RGB pixel per beat in, one HSV result per beat out.
// Throughput is one pixel per clock while the output takes every beat. First,
// one front stage forms max, min and the two divisions' operands, then a row of HUE_BITS
// division cells each settles one hue bit and one saturation bit. Each cell holds its own
// beat and moves on when the next cell frees up, so stalls at the output back up the
// row through the ready chain and bubbles close up. val_out is the largest channel, sat_out
// is (max-min)*255/max truncated (0 for black), hue_out is the truncated fraction of a
// turn times 2^HUE_BITS (0 for gray); ties for the maximum go red, then green, then blue.
// Reset clears only the valid flags; no state carries from one pixel to the next.
`timescale 1ns / 1ps
module rgb_to_hsv_convert_top (
	input  logic       clk,
	input  logic       arst_n,
	rhc_rgb_if.sink    in_pix,
	rhc_hsv_if.source  out_hsv
);
	localparam int N = rhc_pkg::HUE_BITS;

	// stage k feeds cell k; stage N is the output register
	rhc_pkg::cell_data_t stage_data [0:N];
	logic                stage_valid [0:N];
	logic                stage_ready [0:N];

	rhc_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (in_pix),
		.valid  (stage_valid[0]),
		.data   (stage_data[0]),
		.ready  (stage_ready[0])
	);

	// division row, MSB of both quotients first
	for (genvar k = 0; k < N; k++) begin : g_cell
		rhc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[k]),
			.in_data   (stage_data[k]),
			.in_ready  (stage_ready[k]),
			.out_valid (stage_valid[k+1]),
			.out_data  (stage_data[k+1]),
			.out_ready (stage_ready[k+1])
		);
	end

	// last cell's register drives the output beat directly
	assign stage_ready[N] = out_hsv.ready;
	assign out_hsv.valid   = stage_valid[N];
	assign out_hsv.hue_out = stage_data[N].hue_q;
	assign out_hsv.sat_out = stage_data[N].sat_q;
	assign out_hsv.val_out = stage_data[N].val;
endmodule

// File: rtl/core/rhc_checker.sv
// Port-level checks for rgb_to_hsv_convert_top, bound to every instance.
// Depends on rhc_pkg and rgb_to_hsv_convert_top_macros.svh.
`timescale 1ns / 1ps
`include "rgb_to_hsv_convert_top_macros.svh"
module rhc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rhc_pkg::HUE_BITS-1:0] hue_out,
	input logic [rhc_pkg::CH_W-1:0]     sat_out,
	input logic [rhc_pkg::CH_W-1:0]     val_out
);
	// empty output register means every cell can move, so input is open
	`RHC_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)
	// zero saturation only for gray, and gray has zero hue
	`RHC_ASSERT_NOW(a_gray_hue, out_valid && sat_out == '0, hue_out == '0)
	// black pixel has no saturation
	`RHC_ASSERT_NOW(a_black_sat, out_valid && val_out == '0, sat_out == '0)
	// stalled beat holds
	`RHC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(hue_out) && $stable(sat_out) && $stable(val_out))
endmodule

bind rgb_to_hsv_convert_top rhc_checker u_rhc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_pix.ready),
	.out_valid (out_hsv.valid),
	.out_ready (out_hsv.ready),
	.hue_out   (out_hsv.hue_out),
	.sat_out   (out_hsv.sat_out),
	.val_out   (out_hsv.val_out)
);
